>>> design/srt_pkg.sv
// Package for the single request tracker: command and event codes,
// register indexes and the structs passed between the tracker modules.
// No dependencies.
package srt_pkg;

	// Command codes carried in the cmd field of an input item.
	localparam logic [2:0] CMD_TICK     = 3'd0;
	localparam logic [2:0] CMD_START    = 3'd1;
	localparam logic [2:0] CMD_COMPLETE = 3'd2;
	localparam logic [2:0] CMD_CANCEL   = 3'd3;
	localparam logic [2:0] CMD_TAKE     = 3'd4;

	// Event kinds kept in the mailbox.
	localparam logic [1:0] KIND_TIMED_OUT = 2'd0;
	localparam logic [1:0] KIND_REJECTED  = 2'd1;
	localparam logic [1:0] KIND_COMPLETED = 2'd2;
	localparam logic [1:0] KIND_CANCELLED = 2'd3;

	// Configuration register indexes.
	localparam int unsigned CFG_ADDR_W = 2;
	localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT_MS   = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_ACTION   = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_PLAIN_ACTION = 2'd2;

	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned ACTION_W   = 8;

	// Configuration register contents.
	typedef struct packed {
		logic [TIME_W-1:0]   timeout_ms;
		logic [ACTION_W-1:0] max_action;
		logic [ACTION_W-1:0] plain_action;
	} cfg_t;

	// Input item fields other than the request identifier.
	typedef struct packed {
		logic [2:0]          cmd;
		logic [TIME_W-1:0]   now_time;
		logic                reply_present;
		logic [ACTION_W-1:0] reply_action;
	} item_t;

	// Result fields other than the event identifier.
	typedef struct packed {
		logic                accepted;
		logic                busy_res;
		logic                event_valid;
		logic [1:0]          event_kind;
		logic [ACTION_W-1:0] event_action;
	} res_t;

	// Tracker status seen by the top level.
	typedef struct packed {
		logic active;
		logic pending;
	} status_t;

endpackage

>>> design/srt_engine.sv
// Tracker state and the per-item decision logic of the request tracker.
// Computes one result per accepted item and updates the state at the same edge.
// Depends on srt_pkg.
module srt_engine #(
	parameter int unsigned ID_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  srt_pkg::item_t      item,
	input  logic [ID_WIDTH-1:0] req_id,
	input  srt_pkg::cfg_t       cfg,
	output srt_pkg::res_t       res,
	output logic [ID_WIDTH-1:0] res_req_id,
	output srt_pkg::status_t    status
);

	logic                        active_q;
	logic [ID_WIDTH-1:0]         active_req_q;
	logic [ID_WIDTH-1:0]         last_req_q;
	logic [srt_pkg::TIME_W-1:0]  start_time_q;
	logic                        pending_q;
	logic [1:0]                  stored_kind_q;
	logic [ID_WIDTH-1:0]         stored_req_q;
	logic [srt_pkg::ACTION_W-1:0] stored_action_q;

	logic                        active_d;
	logic [ID_WIDTH-1:0]         active_req_d;
	logic [ID_WIDTH-1:0]         last_req_d;
	logic [srt_pkg::TIME_W-1:0]  start_time_d;
	logic                        pending_d;
	logic [1:0]                  stored_kind_d;
	logic [ID_WIDTH-1:0]         stored_req_d;
	logic [srt_pkg::ACTION_W-1:0] stored_action_d;

	logic [srt_pkg::TIME_W-1:0]  elapsed;
	logic                        timed_out;
	logic                        live;
	logic                        id_match;
	logic                        reply_ok;

	// Wrap-safe timeout test against the start time.
	assign elapsed   = item.now_time - start_time_q;
	assign timed_out = active_q && (elapsed >= cfg.timeout_ms);
	// A complete first applies the timeout, then matches against what is left.
	assign live      = active_q && !timed_out;
	assign id_match  = (req_id == active_req_q);
	assign reply_ok  = item.reply_present && (item.reply_action <= cfg.max_action);

	// Next state and result for the current item.
	always_comb begin
		active_d        = active_q;
		active_req_d    = active_req_q;
		last_req_d      = last_req_q;
		start_time_d    = start_time_q;
		pending_d       = pending_q;
		stored_kind_d   = stored_kind_q;
		stored_req_d    = stored_req_q;
		stored_action_d = stored_action_q;
		res             = '0;
		res_req_id      = '0;

		case (item.cmd)
			srt_pkg::CMD_TICK: begin
				if (timed_out) begin
					active_d        = 1'b0;
					pending_d       = 1'b1;
					stored_kind_d   = srt_pkg::KIND_TIMED_OUT;
					stored_req_d    = active_req_q;
					stored_action_d = cfg.plain_action;
					res.accepted    = 1'b1;
				end
			end
			srt_pkg::CMD_START: begin
				if ((req_id != '0) && !active_q && !pending_q && (req_id > last_req_q)) begin
					active_d     = 1'b1;
					active_req_d = req_id;
					last_req_d   = req_id;
					start_time_d = item.now_time;
					res.accepted = 1'b1;
				end
			end
			srt_pkg::CMD_COMPLETE: begin
				if (timed_out) begin
					active_d        = 1'b0;
					pending_d       = 1'b1;
					stored_kind_d   = srt_pkg::KIND_TIMED_OUT;
					stored_req_d    = active_req_q;
					stored_action_d = cfg.plain_action;
				end else if (live && id_match) begin
					active_d     = 1'b0;
					pending_d    = 1'b1;
					stored_req_d = req_id;
					res.accepted = 1'b1;
					if (reply_ok) begin
						stored_kind_d   = srt_pkg::KIND_COMPLETED;
						stored_action_d = item.reply_action;
					end else begin
						stored_kind_d   = srt_pkg::KIND_REJECTED;
						stored_action_d = cfg.plain_action;
					end
				end
			end
			srt_pkg::CMD_CANCEL: begin
				if (active_q && id_match) begin
					active_d        = 1'b0;
					pending_d       = 1'b1;
					stored_kind_d   = srt_pkg::KIND_CANCELLED;
					stored_req_d    = req_id;
					stored_action_d = cfg.plain_action;
					res.accepted    = 1'b1;
				end
			end
			srt_pkg::CMD_TAKE: begin
				if (pending_q) begin
					pending_d        = 1'b0;
					res.accepted     = 1'b1;
					res.event_valid  = 1'b1;
					res.event_kind   = stored_kind_q;
					res.event_action = stored_action_q;
					res_req_id       = stored_req_q;
				end
			end
			default: begin
			end
		endcase

		res.busy_res = active_d;
	end

	// State registers, updated only on an accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q        <= 1'b0;
			active_req_q    <= '0;
			last_req_q      <= '0;
			start_time_q    <= '0;
			pending_q       <= 1'b0;
			stored_kind_q   <= '0;
			stored_req_q    <= '0;
			stored_action_q <= '0;
		end else if (fire) begin
			active_q        <= active_d;
			active_req_q    <= active_req_d;
			last_req_q      <= last_req_d;
			start_time_q    <= start_time_d;
			pending_q       <= pending_d;
			stored_kind_q   <= stored_kind_d;
			stored_req_q    <= stored_req_d;
			stored_action_q <= stored_action_d;
		end
	end

	assign status.active  = active_q;
	assign status.pending = pending_q;

endmodule

>>> design/single_request_tracker_with_timeout.sv
// Single request tracker with timeout: top level with stream ports.
// Results are held in the result register, entering the skid register first while a
// result is stalled. Throughput: one item per cycle while the skid register is empty;
// this two-entry output stage keeps the slave side open for one item during a stall.
// Reset: arst_n clears the tracker state and both output entries and loads the
// register reset values (timeout 30000 ms, actions 0). Depends on srt_pkg, srt_engine.
module single_request_tracker_with_timeout #(
	parameter int unsigned ID_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write port.
	input  logic                            cfg_we,
	input  logic [srt_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [srt_pkg::CFG_DATA_W-1:0]  cfg_data,
	// Slave side.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// s_tdata from bit 0: cmd, req_id, now_time, reply_present, reply_action, zero pad
	input  logic [((3+ID_WIDTH+srt_pkg::TIME_W+1+srt_pkg::ACTION_W+7)/8)*8-1:0] s_tdata,
	// Master side.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// m_tdata from bit 0: accepted, busy_res, event_valid, event_kind, event_req_id,
	// event_action, zero pad
	output logic [((5+ID_WIDTH+srt_pkg::ACTION_W+7)/8)*8-1:0] m_tdata
);

	localparam int unsigned ID_LO   = 3;
	localparam int unsigned TIME_LO = ID_LO + ID_WIDTH;
	localparam int unsigned RP_BIT  = TIME_LO + srt_pkg::TIME_W;
	localparam int unsigned RA_LO   = RP_BIT + 1;
	localparam int unsigned RES_W   = 5 + ID_WIDTH + srt_pkg::ACTION_W;

	srt_pkg::cfg_t         cfg_q;
	srt_pkg::item_t        item;
	logic [ID_WIDTH-1:0]   req_id;
	srt_pkg::res_t         res;
	logic [ID_WIDTH-1:0]   res_req_id;
	srt_pkg::status_t      status;
	logic                  in_fire;
	logic [RES_W-1:0]      res_vec;
	logic [RES_W-1:0]      out_data_q;
	logic [RES_W-1:0]      skid_data_q;
	logic                  out_valid_q;
	logic                  skid_valid_q;
	logic                  out_free;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ms   <= srt_pkg::TIME_W'(30000);
			cfg_q.max_action   <= '0;
			cfg_q.plain_action <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				srt_pkg::REG_TIMEOUT_MS:   cfg_q.timeout_ms   <= cfg_data;
				srt_pkg::REG_MAX_ACTION:   cfg_q.max_action   <= cfg_data[srt_pkg::ACTION_W-1:0];
				srt_pkg::REG_PLAIN_ACTION: cfg_q.plain_action <= cfg_data[srt_pkg::ACTION_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Unpack the input item.
	assign item.cmd           = s_tdata[2:0];
	assign req_id             = s_tdata[ID_LO +: ID_WIDTH];
	assign item.now_time      = s_tdata[TIME_LO +: srt_pkg::TIME_W];
	assign item.reply_present = s_tdata[RP_BIT];
	assign item.reply_action  = s_tdata[RA_LO +: srt_pkg::ACTION_W];

	assign s_tready = !skid_valid_q;
	assign in_fire  = s_tvalid && s_tready;

	srt_engine #(
		.ID_WIDTH(ID_WIDTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (in_fire),
		.item      (item),
		.req_id    (req_id),
		.cfg       (cfg_q),
		.res       (res),
		.res_req_id(res_req_id),
		.status    (status)
	);

	// Pack the result in port order.
	assign res_vec = {res.event_action, res_req_id, res.event_kind,
		res.event_valid, res.busy_res, res.accepted};

	// The result register can take a new entry when empty or being drained.
	assign out_free = m_tready || !out_valid_q;

	// Occupancy of the result register and the skid register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_fire;
			end
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Result payload moves without reset.
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (in_fire) begin
				out_data_q <= res_vec;
			end
		end else if (in_fire) begin
			skid_data_q <= res_vec;
		end
	end

	assign m_tvalid = out_valid_q;

	always_comb begin
		m_tdata           = '0;
		m_tdata[RES_W-1:0] = out_data_q;
	end

`ifndef ASSERT_OFF
	// The skid register only fills behind a waiting result.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while result register is empty");

	// An accepted start leaves a request active.
	a_start_sets_active: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && item.cmd == srt_pkg::CMD_START && res.accepted) |=> status.active)
		else $error("accepted start did not activate the tracker");

	// A taken event empties the mailbox.
	a_take_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && item.cmd == srt_pkg::CMD_TAKE && res.event_valid) |=> !status.pending)
		else $error("mailbox still pending after an event was taken");

	// An event can only be taken from a full mailbox.
	a_take_needs_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && res.event_valid) |-> status.pending)
		else $error("event reported with an empty mailbox");
`endif

endmodule

>>> tb/tb.sv
// Testbench for the single request tracker with timeout: directed and random
// command traffic, checked against an in-bench prediction of the tracker.
// Depends on srt_pkg and single_request_tracker_with_timeout.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned QUIET_LIMIT = 2000;

	// One result item as it sits in m_tdata[44:0], last field first.
	typedef struct packed {
		logic [7:0]  ev_action;
		logic [31:0] ev_req;
		logic [1:0]  ev_kind;
		logic        ev_valid;
		logic        busy;
		logic        accepted;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_addr = '0;
	logic [31:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;

	// Predicted tracker registers and state.
	logic [31:0] m_timeout = 32'd30000;
	logic [7:0]  m_max_action = '0;
	logic [7:0]  m_plain_action = '0;
	logic        m_active = 1'b0;
	logic [31:0] m_active_req = '0;
	logic [31:0] m_last = '0;
	logic [31:0] m_start = '0;
	logic        m_pending = 1'b0;
	logic [1:0]  m_kind = '0;
	logic [31:0] m_ev_req = '0;
	logic [7:0]  m_ev_action = '0;

	outcome_t    tracker_outcomes[$];
	int unsigned fail_count = 0;
	int unsigned item_count = 0;
	int unsigned quiet_cycles = 0;
	int unsigned send_idle_pct = 29;
	int unsigned recv_idle_pct = 76;

	always #2 clk = ~clk;

	single_request_tracker_with_timeout #(.ID_WIDTH(32)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Store one ending of a request in the mailbox, replacing any old event.
	function automatic void post_ending(logic [1:0] kind, logic [31:0] id, logic [7:0] action);
		m_kind = kind;
		m_ev_req = id;
		m_ev_action = action;
		m_pending = 1'b1;
	endfunction

	// End the active request when the wrapping elapsed time reaches the timeout.
	function automatic logic expire(logic [31:0] now);
		logic [31:0] elapsed;
		if (!m_active)
			return 1'b0;
		elapsed = now - m_start;
		if (elapsed < m_timeout)
			return 1'b0;
		m_active = 1'b0;
		post_ending(srt_pkg::KIND_TIMED_OUT, m_active_req, m_plain_action);
		m_active_req = '0;
		return 1'b1;
	endfunction

	// Advance the predicted tracker by one command and return its result.
	function automatic outcome_t tracker_outcome(logic [2:0] cmd, logic [31:0] id,
			logic [31:0] now, logic rp, logic [7:0] ra);
		outcome_t o;
		o = '0;
		case (cmd)
			srt_pkg::CMD_TICK: begin
				o.accepted = expire(now);
			end
			srt_pkg::CMD_START: begin
				if (id != 0 && !m_active && !m_pending && id > m_last) begin
					m_active_req = id;
					m_last = id;
					m_start = now;
					m_active = 1'b1;
					o.accepted = 1'b1;
				end
			end
			srt_pkg::CMD_COMPLETE: begin
				void'(expire(now));
				if (m_active && id == m_active_req) begin
					m_active = 1'b0;
					m_active_req = '0;
					if (!rp || ra > m_max_action)
						post_ending(srt_pkg::KIND_REJECTED, id, m_plain_action);
					else
						post_ending(srt_pkg::KIND_COMPLETED, id, ra);
					o.accepted = 1'b1;
				end
			end
			srt_pkg::CMD_CANCEL: begin
				if (m_active && id == m_active_req) begin
					m_active = 1'b0;
					m_active_req = '0;
					post_ending(srt_pkg::KIND_CANCELLED, id, m_plain_action);
					o.accepted = 1'b1;
				end
			end
			srt_pkg::CMD_TAKE: begin
				if (m_pending) begin
					m_pending = 1'b0;
					o.accepted = 1'b1;
					o.ev_valid = 1'b1;
					o.ev_kind = m_kind;
					o.ev_req = m_ev_req;
					o.ev_action = m_ev_action;
				end
			end
			default: begin
			end
		endcase
		o.busy = m_active;
		return o;
	endfunction

	// Drive one item after an optional random gap and record its expected result.
	task automatic send_item(logic [2:0] cmd, logic [31:0] id, logic [31:0] now,
			logic rp, logic [7:0] ra);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, ra, rp, now, id, cmd};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tracker_outcomes.push_back(tracker_outcome(cmd, id, now, rp, ra));
		item_count++;
	endtask

	// Write one register once every outstanding item has produced its result.
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		s_tvalid <= 1'b0;
		while (tracker_outcomes.size() != 0)
			@(posedge clk);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			srt_pkg::REG_TIMEOUT_MS:   m_timeout = val;
			srt_pkg::REG_MAX_ACTION:   m_max_action = val[7:0];
			srt_pkg::REG_PLAIN_ACTION: m_plain_action = val[7:0];
			default: begin
			end
		endcase
	endtask

	// Elapsed time for a tick or complete: well short of, just under, at, or anywhere.
	function automatic logic [31:0] pick_elapsed(logic [31:0] tmo);
		case ($urandom_range(3))
			0: return $urandom_range(0, tmo / 2);
			1: return tmo - 1;
			2: return tmo;
			default: return $urandom;
		endcase
	endfunction

	// Reset register values: refusals, timeout inside a complete, wrap of time.
	task automatic test_basic_commands();
		send_item(srt_pkg::CMD_TAKE, '0, '0, 1'b0, '0);
		send_item(srt_pkg::CMD_TICK, '0, '0, 1'b0, '0);
		send_item(srt_pkg::CMD_START, '0, 32'd100, 1'b1, 8'hFF);
		send_item(srt_pkg::CMD_START, 32'd5, 32'd100, 1'b0, '0);
		send_item(srt_pkg::CMD_START, 32'd6, 32'd100, 1'b0, '0);
		send_item(srt_pkg::CMD_CANCEL, 32'd4, '0, 1'b0, '0);
		send_item(srt_pkg::CMD_TICK, '0, 32'd100 + 32'd29999, 1'b0, '0);
		// The timeout fires first, so the complete itself finds nothing active.
		send_item(srt_pkg::CMD_COMPLETE, 32'd5, 32'd100 + 32'd30000, 1'b1, '0);
		send_item(srt_pkg::CMD_START, 32'd7, 32'd200, 1'b0, '0);
		send_item(srt_pkg::CMD_TAKE, '0, '0, 1'b0, '0);
		send_item(srt_pkg::CMD_START, 32'd5, 32'd200, 1'b0, '0);
		// Start near the top of time so the complete sees a wrapped clock.
		send_item(srt_pkg::CMD_START, 32'd7, 32'hFFFF_FFF0, 1'b0, '0);
		send_item(srt_pkg::CMD_COMPLETE, 32'd7, 32'h0000_0010, 1'b1, '0);
		send_item(srt_pkg::CMD_TAKE, '0, '0, 1'b0, '0);
		send_item(srt_pkg::CMD_START, 32'd8, 32'd300, 1'b0, '0);
		send_item(srt_pkg::CMD_COMPLETE, 32'd8, 32'd301, 1'b0, '0);
		send_item(srt_pkg::CMD_TAKE, '0, '0, 1'b0, '0);
		send_item(3'd5, $urandom, $urandom, 1'b1, 8'($urandom));
		send_item(3'd6, $urandom, $urandom, 1'b0, 8'($urandom));
		send_item(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF);
	endtask

	// Extreme register values: zero and full timeout, widest action limit.
	task automatic test_register_extremes();
		write_reg(srt_pkg::REG_TIMEOUT_MS, '0);
		write_reg(srt_pkg::REG_PLAIN_ACTION, 32'hFF);
		send_item(srt_pkg::CMD_START, 32'd9, 32'h1234_5678, 1'b0, '0);
		send_item(srt_pkg::CMD_COMPLETE, 32'd9, 32'h1234_5678, 1'b1, 8'd0);
		send_item(srt_pkg::CMD_TAKE, '0, '0, 1'b0, '0);
		write_reg(srt_pkg::REG_TIMEOUT_MS, 32'hFFFF_FFFF);
		write_reg(srt_pkg::REG_MAX_ACTION, 32'hFF);
		send_item(srt_pkg::CMD_START, 32'd10, '0, 1'b0, '0);
		send_item(srt_pkg::CMD_TICK, '0, 32'hFFFF_FFFE, 1'b0, '0);
		send_item(srt_pkg::CMD_COMPLETE, 32'd10, 32'hFFFF_FFFE, 1'b1, 8'hFF);
		send_item(srt_pkg::CMD_TAKE, '0, '0, 1'b0, '0);
		send_item(srt_pkg::CMD_START, 32'd11, '0, 1'b0, '0);
		send_item(srt_pkg::CMD_TICK, '0, 32'hFFFF_FFFF, 1'b0, '0);
		send_item(srt_pkg::CMD_TAKE, '0, '0, 1'b0, '0);
	endtask

	// Random request lifetimes with random content, mixed with noise items.
	task automatic test_random_traffic(int unsigned n_items, logic [31:0] tmo,
			logic [7:0] max_a, logic [7:0] plain_a, int unsigned s_idle, int unsigned r_idle);
		logic [31:0] id;
		logic [31:0] t0;
		int unsigned target;
		write_reg(srt_pkg::REG_TIMEOUT_MS, tmo);
		write_reg(srt_pkg::REG_MAX_ACTION, 32'(max_a));
		write_reg(srt_pkg::REG_PLAIN_ACTION, 32'(plain_a));
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		target = item_count + n_items;
		while (item_count < target) begin
			if ($urandom_range(99) < 75) begin
				if ($urandom_range(9) == 0)
					id = m_last + $urandom_range(1, 32'h0040_0000);
				else
					id = m_last + $urandom_range(1, 16);
				t0 = $urandom;
				send_item(srt_pkg::CMD_START, id, t0, 1'($urandom), 8'($urandom));
				repeat ($urandom_range(0, 3))
					send_item(srt_pkg::CMD_TICK, $urandom, t0 + pick_elapsed(m_timeout),
						1'($urandom), 8'($urandom));
				case ($urandom_range(9))
					0, 1, 2, 3, 4: begin
						send_item(srt_pkg::CMD_COMPLETE,
							($urandom_range(9) == 0) ? id ^ (32'd1 << $urandom_range(31)) : id,
							t0 + pick_elapsed(m_timeout), ($urandom_range(9) != 0), 8'($urandom));
					end
					5, 6, 7: begin
						send_item(srt_pkg::CMD_CANCEL,
							($urandom_range(9) == 0) ? id ^ (32'd1 << $urandom_range(31)) : id,
							$urandom, 1'($urandom), 8'($urandom));
					end
					default: begin
						send_item(srt_pkg::CMD_TICK, $urandom, t0 + m_timeout, 1'($urandom),
							8'($urandom));
					end
				endcase
				// Leaving an event untaken now and then blocks the next start.
				if ($urandom_range(99) < 85)
					send_item(srt_pkg::CMD_TAKE, $urandom, $urandom, 1'($urandom), 8'($urandom));
			end else begin
				send_item(3'($urandom_range(7)), $urandom, $urandom, 1'($urandom), 8'($urandom));
			end
		end
	endtask

	// The largest identifier is accepted at most once and can never be followed.
	task automatic test_id_ceiling();
		send_item(srt_pkg::CMD_START, 32'hFFFF_FFFF, 32'd5, 1'b0, '0);
		send_item(srt_pkg::CMD_CANCEL, 32'hFFFF_FFFF, '0, 1'b0, '0);
		send_item(srt_pkg::CMD_TAKE, '0, '0, 1'b0, '0);
		send_item(srt_pkg::CMD_START, 32'hFFFF_FFFF, 32'd6, 1'b0, '0);
	endtask

	// Receiver side readiness, idling at the current rate.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Compare each result item with the oldest expectation.
	always @(posedge clk) begin
		outcome_t got;
		outcome_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = outcome_t'(m_tdata[44:0]);
			if (tracker_outcomes.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result item %h", got);
			end else begin
				want = tracker_outcomes.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= 10)
						$display({"mismatch: acc %b/%b busy %b/%b valid %b/%b kind %0d/%0d ",
							"id %h/%h action %h/%h (expected/actual)"},
							want.accepted, got.accepted, want.busy, got.busy,
							want.ev_valid, got.ev_valid, want.ev_kind, got.ev_kind,
							want.ev_req, got.ev_req, want.ev_action, got.ev_action);
				end
			end
		end
	end

	// Watchdog on cycles in which neither side moves an item.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("single_request_tracker_with_timeout verification failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_commands();
		test_register_extremes();
		test_random_traffic(170, $urandom_range(1, 400), 8'($urandom), 8'($urandom), 29, 76);
		test_random_traffic(170, $urandom, 8'hFF, 8'h00, 76, 29);
		test_random_traffic(160, $urandom_range(2, 50), 8'h80, 8'hFF, 0, 0);
		test_id_ceiling();
		s_tvalid <= 1'b0;
		while (tracker_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("single_request_tracker_with_timeout verification clean");
		else
			$display("single_request_tracker_with_timeout verification failed");
		$finish;
	end

endmodule

>>> single_request_tracker_with_timeout.f
design/srt_pkg.sv
design/srt_engine.sv
design/single_request_tracker_with_timeout.sv
tb/tb.sv
